// ===== sv/rc4_keystream_cipher_unit_defines.svh =====
// Assertion helpers shared by the RC4 unit.
// Both expect clk and rst_n in scope.
`ifndef RC4_KEYSTREAM_CIPHER_UNIT_DEFINES_SVH
`define RC4_KEYSTREAM_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RC4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RC4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rc4_pkg.sv =====
package rc4_pkg;

  localparam int BYTE_W            = 8;
  localparam int PERM_SIZE         = 256;
  localparam int CFG_W             = 64;
  localparam int CFG_IDX_W         = 2;
  localparam int KEYLEN_W          = 5;
  localparam int CNT_W             = 16;
  localparam int CMD_W             = 2;
  localparam int KEY_REG_BYTES     = 16;
  localparam int MAX_KEY_BYTES_DEF = 16;
  localparam int KEYLEN_RESET      = 16;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd2;

  // commands
  localparam logic [CMD_W-1:0] CMD_KSCHED = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SKIP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CRYPT  = 2'd2;

  // microprogram addresses
  typedef enum logic [3:0] {
    PC_IDLE, PC_CR_RD, PC_CR_A, PC_CR_B, PC_CR_C,
    PC_SK_CHK, PC_SK_RD, PC_SK_A, PC_SK_B, PC_SK_C,
    PC_KS_CLR, PC_KS_RD, PC_KS_A, PC_KS_B, PC_KS_C, PC_KS_END
  } pc_t;

  typedef enum logic [2:0] {A_NONE, A_I, A_I1, A_JSUM, A_JKEY, A_T} addr_sel_t;
  typedef enum logic [1:0] {W_NONE, W_I, W_J} wr_sel_t;
  typedef enum logic [1:0] {I_HOLD, I_INC, I_INC_TAKEN, I_CLR} i_op_t;
  typedef enum logic [1:0] {J_HOLD, J_LOAD, J_CLR} j_op_t;
  typedef enum logic [1:0] {K_HOLD, K_CLR, K_ADV} k_op_t;
  typedef enum logic [2:0] {C_NEVER, C_ALWAYS, C_CNT_ZERO, C_CNT_MORE, C_I_NOT_LAST} cond_t;

  typedef struct packed {
    addr_sel_t addr;
    wr_sel_t   wr;
    i_op_t     iop;
    j_op_t     jop;
    k_op_t     kop;
    logic      ld_si;
    logic      ld_tj;
    logic      clr_vld;
    logic      cnt_dec;
    logic      emit;
    logic      fin;
    cond_t     cond;
    pc_t       target;
  } ucw_t;

  localparam ucw_t UCW_NOP = '{
    addr: A_NONE, wr: W_NONE, iop: I_HOLD, jop: J_HOLD, kop: K_HOLD,
    ld_si: 1'b0, ld_tj: 1'b0, clr_vld: 1'b0, cnt_dec: 1'b0, emit: 1'b0,
    fin: 1'b0, cond: C_NEVER, target: PC_IDLE
  };

  // Control store. Generator step: read S[i+1], read S[j], swap + read S[t].
  function automatic ucw_t ucode_rom(pc_t pc);
    ucw_t w;
    w = UCW_NOP;
    unique case (pc)
      PC_IDLE: ;
      PC_CR_RD, PC_SK_RD: begin
        w.addr = A_I1;
        w.iop  = I_INC;
      end
      PC_CR_A, PC_SK_A: begin
        w.addr  = A_JSUM;
        w.jop   = J_LOAD;
        w.ld_si = 1'b1;
      end
      PC_CR_B, PC_SK_B: begin
        w.addr  = A_T;
        w.wr    = W_I;
        w.ld_tj = 1'b1;
      end
      PC_CR_C: begin
        w.wr     = W_J;
        w.emit   = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = PC_IDLE;
      end
      PC_SK_CHK: begin
        w.cond   = C_CNT_ZERO;
        w.target = PC_IDLE;
      end
      PC_SK_C: begin
        w.addr    = A_I1;
        w.wr      = W_J;
        w.iop     = I_INC_TAKEN;
        w.cnt_dec = 1'b1;
        w.cond    = C_CNT_MORE;
        w.target  = PC_SK_A;
        w.fin     = 1'b1;
      end
      PC_KS_CLR: begin
        w.iop     = I_CLR;
        w.jop     = J_CLR;
        w.kop     = K_CLR;
        w.clr_vld = 1'b1;
      end
      PC_KS_RD: begin
        w.addr = A_I;
      end
      PC_KS_A: begin
        w.addr  = A_JKEY;
        w.jop   = J_LOAD;
        w.ld_si = 1'b1;
      end
      PC_KS_B: begin
        w.wr = W_I;
      end
      PC_KS_C: begin
        w.addr   = A_I1;
        w.wr     = W_J;
        w.iop    = I_INC_TAKEN;
        w.kop    = K_ADV;
        w.cond   = C_I_NOT_LAST;
        w.target = PC_KS_A;
      end
      PC_KS_END: begin
        w.iop    = I_CLR;
        w.jop    = J_CLR;
        w.cond   = C_ALWAYS;
        w.target = PC_IDLE;
      end
      default: w = UCW_NOP;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/rc4_ram.sv =====
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rc4_keystream_cipher_unit.sv =====
// RC4 keystream unit. cmd 0 runs the key schedule over key_length bytes of the two
// key registers (zero length acts as 1, lengths above MAX_KEY_BYTES saturate),
// cmd 1 discards skip_count keystream bytes, cmd 2 XORs data_in with the next
// keystream byte and returns one transfer on the out channel with last_in echoed;
// cmd 3 is dropped. Items are handled one at a time. Each keystream byte needs
// three reads and two writes of the 256-byte permutation, which lives in one
// RAM with one read and one write port. Reset needs no sweep: a per-entry
// valid bit makes unwritten entries read as the identity, and the key schedule
// starts by dropping all valid bits. A pending result sits in an output
// register, so the next item is taken while it waits; a crypt stalls in its
// last step only if the previous result has not been taken yet.
// Configuration writes (key registers, key_length) land at once and belong
// only in idle periods.
`include "rc4_keystream_cipher_unit_defines.svh"

module rc4_keystream_cipher_unit #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rc4_pkg::CFG_W-1:0]       cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rc4_pkg::CMD_W-1:0]       in_cmd,
  input  logic [rc4_pkg::BYTE_W-1:0]      in_data_in,
  input  logic [rc4_pkg::CNT_W-1:0]       in_skip_count,
  input  logic                            in_last_in,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]      out_data_out,
  output logic                            out_last_out
);

  import rc4_pkg::*;

  // key index counter only needs to reach MAX_KEY_BYTES-1
  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int LW = 6;  // holds lengths up to 32

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  pc_t                 pc_r, pc_nxt;
  logic [CFG_W-1:0]    key_lo_r, key_hi_r;
  logic [KEYLEN_W-1:0] key_len_r;
  logic [BYTE_W-1:0]   i_r, i_nxt;
  logic [BYTE_W-1:0]   j_r, j_nxt;
  logic [KW-1:0]       kidx_r, kidx_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [BYTE_W-1:0]   data_r;
  logic                last_r;
  logic [BYTE_W-1:0]   si_r;          // S[i] captured before the swap
  logic                tj_r;          // keystream index hits j
  logic [PERM_SIZE-1:0] valid_r;      // entry written since last identity load
  // read-side tracking for the RAM's registered output
  logic                vld_r;
  logic                hit_r;
  logic [BYTE_W-1:0]   fwd_r;
  logic [BYTE_W-1:0]   raddr_r;
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_data_r;
  logic                out_last_r;

  // ---------------------------------------------------------------------------
  // Datapath signals
  // ---------------------------------------------------------------------------
  ucw_t                uw;
  logic                en;
  logic                taken;
  logic [BYTE_W-1:0]   ram_q;
  logic [BYTE_W-1:0]   rd_eff;
  logic [BYTE_W-1:0]   ks_byte;
  logic [BYTE_W-1:0]   i_inc;
  logic [BYTE_W-1:0]   rd_addr;
  logic                rd_en;
  logic [BYTE_W-1:0]   wr_addr;
  logic [BYTE_W-1:0]   wr_data;
  logic                wr_en;
  logic [LW-1:0]       len_eff;
  logic [LW-1:0]       kidx6;
  logic [2*CFG_W-1:0]  key_all;
  logic [BYTE_W-1:0]   key_byte;
  logic                accept;

  assign uw     = ucode_rom(pc_r);
  assign accept = in_valid && in_ready;

  // Hold the whole step while a new result cannot be parked.
  assign en = !(uw.emit && out_valid_r && !out_ready);

  // Effective read: newest write wins, unwritten entries read as identity.
  assign rd_eff  = hit_r ? fwd_r : (vld_r ? ram_q : raddr_r);
  // If S[t] is the slot swapped last (j), its new value is still in si_r.
  assign ks_byte = tj_r ? si_r : rd_eff;
  assign i_inc   = i_r + 8'd1;

  // Key length clamp and key byte select.
  always_comb begin
    len_eff = LW'(key_len_r);
    if (key_len_r == '0) begin
      len_eff = LW'(1);
    end else if (LW'(key_len_r) > LW'(MAX_KEY_BYTES)) begin
      len_eff = LW'(MAX_KEY_BYTES);
    end
  end

  assign kidx6   = LW'(kidx_r);
  assign key_all = {key_hi_r, key_lo_r};

  always_comb begin
    key_byte = '0;
    if (kidx6 < LW'(KEY_REG_BYTES)) begin
      key_byte = key_all[{kidx6[3:0], 3'b000} +: BYTE_W];
    end
  end

  // Jump condition.
  always_comb begin
    unique case (uw.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_CNT_ZERO:   taken = (cnt_r == '0);
      C_CNT_MORE:   taken = (cnt_r != CNT_W'(1));
      C_I_NOT_LAST: taken = (i_r != '1);
      default:      taken = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer next step
  // ---------------------------------------------------------------------------
  always_comb begin
    pc_nxt = pc_r;
    if (pc_r == PC_IDLE) begin
      if (in_valid) begin
        unique case (in_cmd)
          CMD_KSCHED: pc_nxt = PC_KS_CLR;
          CMD_SKIP:   pc_nxt = PC_SK_CHK;
          CMD_CRYPT:  pc_nxt = PC_CR_RD;
          default:    pc_nxt = PC_IDLE;
        endcase
      end
    end else if (en) begin
      if (taken) begin
        pc_nxt = uw.target;
      end else if (uw.fin) begin
        pc_nxt = PC_IDLE;
      end else begin
        pc_nxt = pc_t'(pc_r + 4'd1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Control word decode: RAM ports and index updates
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready = (pc_r == PC_IDLE);

    rd_addr = i_r;
    unique case (uw.addr)
      A_NONE:  rd_addr = i_r;
      A_I:     rd_addr = i_r;
      A_I1:    rd_addr = i_inc;
      A_JSUM:  rd_addr = j_r + rd_eff;
      A_JKEY:  rd_addr = j_r + rd_eff + key_byte;
      A_T:     rd_addr = si_r + rd_eff;
      default: rd_addr = i_r;
    endcase
    rd_en = (uw.addr != A_NONE) && en;

    wr_addr = i_r;
    wr_data = rd_eff;
    unique case (uw.wr)
      W_NONE: begin
        wr_addr = i_r;
        wr_data = rd_eff;
      end
      W_I: begin
        wr_addr = i_r;
        wr_data = rd_eff;
      end
      W_J: begin
        wr_addr = j_r;
        wr_data = si_r;
      end
      default: begin
        wr_addr = i_r;
        wr_data = rd_eff;
      end
    endcase
    wr_en = (uw.wr != W_NONE) && en;

    i_nxt = i_r;
    unique case (uw.iop)
      I_HOLD:      i_nxt = i_r;
      I_INC:       i_nxt = i_inc;
      I_INC_TAKEN: i_nxt = taken ? i_inc : i_r;
      I_CLR:       i_nxt = '0;
      default:     i_nxt = i_r;
    endcase

    j_nxt = j_r;
    unique case (uw.jop)
      J_HOLD:  j_nxt = j_r;
      J_LOAD:  j_nxt = rd_addr;
      J_CLR:   j_nxt = '0;
      default: j_nxt = j_r;
    endcase

    kidx_nxt = kidx_r;
    unique case (uw.kop)
      K_HOLD:  kidx_nxt = kidx_r;
      K_CLR:   kidx_nxt = '0;
      K_ADV:   kidx_nxt = ((kidx6 + LW'(1)) == len_eff) ? '0 : KW'(kidx_r + 1'b1);
      default: kidx_nxt = kidx_r;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Permutation store
  // ---------------------------------------------------------------------------
  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_SIZE)
  ) u_perm (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      key_lo_r    <= '0;
      key_hi_r    <= '0;
      key_len_r   <= KEYLEN_W'(KEYLEN_RESET);
      i_r         <= '0;
      j_r         <= '0;
      kidx_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_LO:  key_lo_r  <= cfg_data;
          CFG_KEY_HI:  key_hi_r  <= cfg_data;
          CFG_KEY_LEN: key_len_r <= cfg_data[KEYLEN_W-1:0];
          default: ;
        endcase
      end
      if (en) begin
        i_r    <= i_nxt;
        j_r    <= j_nxt;
        kidx_r <= kidx_nxt;
      end
      if (uw.clr_vld && en) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      // result register: a new result may replace one taken this cycle
      if (uw.emit && en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r  <= in_skip_count;
      data_r <= in_data_in;
      last_r <= in_last_in;
    end else if (uw.cnt_dec && en) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (uw.ld_si && en) begin
      si_r <= rd_eff;
    end
    if (uw.ld_tj && en) begin
      tj_r <= (rd_addr == j_r);
    end
    if (rd_en) begin
      vld_r   <= valid_r[rd_addr];
      hit_r   <= wr_en && (wr_addr == rd_addr);
      fwd_r   <= wr_data;
      raddr_r <= rd_addr;
    end
    if (uw.emit && en) begin
      out_data_r <= data_r ^ ks_byte;
      out_last_r <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_last_out = out_last_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `RC4_ASSERT_NXT(a_crypt_dispatch, accept && in_cmd == CMD_CRYPT, pc_r == PC_CR_RD,
                  "crypt command did not enter its microprogram")
  `RC4_ASSERT_NXT(a_emit_stall, pc_r == PC_CR_C && out_valid_r && !out_ready,
                  pc_r == PC_CR_C && out_valid_r, "crypt step left while result blocked")
  `RC4_ASSERT_IMP(a_result_src, $rose(out_valid_r), $past(pc_r) == PC_CR_C,
                  "result raised outside the crypt step")
  `RC4_ASSERT_NXT(a_ks_indices, pc_r == PC_KS_END, i_r == '0 && j_r == '0,
                  "key schedule left nonzero indices")
  `RC4_ASSERT_NXT(a_result_drain, out_valid_r && out_ready && pc_r != PC_CR_C, !out_valid_r,
                  "taken result not retired")

endmodule
